// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker of the router.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is asserted.
`define WRBR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property, checked in reset too.
`define WRBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/wrbr_pkg.sv
// Types, constants and helper functions of the weighted random burst router.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package wrbr_pkg;

    localparam int NUM_STEPS    = 8;
    localparam int STEP_IDX_W   = $clog2(NUM_STEPS);
    localparam int CV_BITS      = 16;
    localparam int WEIGHT_BITS  = 8;
    localparam int BASE_BITS    = 24;
    localparam int VAR_BITS     = 7;
    localparam int RAND_BITS    = 16;
    localparam int LANE_BITS    = NUM_STEPS * WEIGHT_BITS;
    localparam int FACTOR_BITS  = 24;
    localparam int PROD_BITS    = BASE_BITS + FACTOR_BITS;
    localparam int QUOT_BITS    = 32;
    localparam int TARGET_BITS  = 25;
    localparam int SUM_BITS     = 11;
    localparam int PICK_BITS    = SUM_BITS + RAND_BITS;
    localparam int MODE_BITS    = 2;

    localparam int IN_TDATA_W   = 120;
    localparam int OUT_TDATA_W  = 144;
    localparam int OUT_CV_LSB   = NUM_STEPS + MODE_BITS;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIATION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MASK   = 2'd3;

    localparam logic [BASE_BITS-1:0] BASE_RESET      = 24'd48000;
    localparam logic [VAR_BITS-1:0]  VAR_RESET       = 7'd50;
    localparam logic [LANE_BITS-1:0] WEIGHTS_RESET   = {LANE_BITS{1'b1}};
    localparam logic [NUM_STEPS-1:0] HOLD_RESET      = '0;
    localparam logic [VAR_BITS-1:0]  VAR_MAX         = 7'd100;

    localparam logic [MODE_BITS-1:0] MODE_PICK       = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_INDEP      = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_ADVANCE    = 2'd2;

    // factor = 100 * 65536 means "no jitter"; target = base * factor / (100 * 65536)
    localparam logic [TARGET_BITS-1:0] FACTOR_UNITY  = 25'd6553600;
    // floor(n / 100) == (n * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit n
    localparam logic [QUOT_BITS-1:0]   DIV100_MAGIC  = 32'h51EB851F;
    localparam int                     DIV100_SHIFT  = 37;

    typedef logic [SUM_BITS-1:0] wrbr_cum_t [NUM_STEPS];

    typedef struct packed {
        logic capture;
        logic prod_en;
        logic quot_en;
        logic eval_en;
    } wrbr_cmd_t;

    typedef struct packed {
        logic draw;
        logic out_free;
    } wrbr_status_t;

    // w/255 > r/256  <=>  w*256 > r*255
    function automatic logic wrbr_passes(input logic [WEIGHT_BITS-1:0] w,
                                         input logic [WEIGHT_BITS-1:0] r);
        logic [15:0] lhs;
        logic [15:0] rhs;
        lhs = {w, 8'h00};
        rhs = {r, 8'h00} - 16'(r);
        return lhs > rhs;
    endfunction

    function automatic wrbr_cum_t wrbr_prefix(input logic [LANE_BITS-1:0] weights);
        wrbr_cum_t        cum;
        logic [SUM_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            acc    = acc + SUM_BITS'(weights[WEIGHT_BITS*i +: WEIGHT_BITS]);
            cum[i] = acc;
        end
        return cum;
    endfunction

endpackage

// File: rtl/core/wrbr_ctrl.sv
// Tick sequencer of the router: accepts a word, steps the target draw and the
// evaluation. Depends on wrbr_pkg; drives wrbr_datapath through wrbr_cmd_t.
`timescale 1ns / 1ps

module wrbr_ctrl
    import wrbr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  wrbr_status_t status,
    output wrbr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROD  = 2'd1;
    localparam logic [1:0] ST_QUOT  = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = status.draw ? ST_PROD : ST_EVAL;
                end
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                state_next  = ST_QUOT;
            end
            ST_QUOT: begin
                cmd.quot_en = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.out_free) begin
                    cmd.eval_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/wrbr_datapath.sv
// Router datapath: config registers, target draw multipliers, step selection,
// CV hold registers and the output word register. Depends on wrbr_pkg.
`timescale 1ns / 1ps

module wrbr_datapath
    import wrbr_pkg::*;
#(
    parameter int TIME_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wrbr_cmd_t              cmd,
    output wrbr_status_t           status,
    input  logic [IN_TDATA_W-1:0]  s_data,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_TDATA_W-1:0] m_data
);

    localparam int CMP_W = (TIME_BITS > TARGET_BITS) ? TIME_BITS : TARGET_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // configuration
    logic [BASE_BITS-1:0]   base_reg;
    logic [VAR_BITS-1:0]    var_reg;
    logic [LANE_BITS-1:0]   weights_reg;
    logic [NUM_STEPS-1:0]   hold_reg;
    wrbr_cum_t              cum_reg;

    // captured word
    logic                   gate_reg;
    logic                   btn_reg;
    logic [CV_BITS-1:0]     cv_reg;
    logic [LANE_BITS-1:0]   lanes_reg;
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [PICK_BITS-1:0]   pick_thr_reg;
    logic                   draw_reg;
    logic [QUOT_BITS-1:0]   scaled_reg;
    logic [2*QUOT_BITS-1:0] recip_reg;

    // tick state
    logic [MODE_BITS-1:0]   mode_reg;
    logic [NUM_STEPS-1:0]   active_reg;
    logic [TIME_BITS-1:0]   elapsed_reg;
    logic [TARGET_BITS-1:0] target_reg;
    logic                   armed_reg;
    logic                   button_prev_reg;
    logic [CV_BITS-1:0]     held_reg [NUM_STEPS];

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // input fields
    logic                   in_gate;
    logic                   in_btn;
    logic [CV_BITS-1:0]     in_cv;
    logic [RAND_BITS-1:0]   in_jitter;
    logic [RAND_BITS-1:0]   in_pick;
    logic [LANE_BITS-1:0]   in_lanes;

    assign in_gate   = s_data[0];
    assign in_btn    = s_data[1];
    assign in_cv     = s_data[2 +: CV_BITS];
    assign in_jitter = s_data[2 + CV_BITS +: RAND_BITS];
    assign in_pick   = s_data[2 + CV_BITS + RAND_BITS +: RAND_BITS];
    assign in_lanes  = s_data[2 + CV_BITS + 2*RAND_BITS +: LANE_BITS];

    assign status.draw     = in_gate & ~armed_reg;
    assign status.out_free = ~out_valid_reg | m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_data_reg;

    // jitter factor and pick threshold, computed at capture
    logic [VAR_BITS-1:0]    var_clamp;
    logic [22:0]            var_jit;
    logic [TARGET_BITS-1:0] factor_wide;
    logic [PICK_BITS-1:0]   pick_thr;

    always_comb begin
        var_clamp   = (var_reg > VAR_MAX) ? VAR_MAX : var_reg;
        var_jit     = 23'(var_clamp) * 23'(in_jitter);
        factor_wide = FACTOR_UNITY + TARGET_BITS'({var_jit, 1'b0})
                      - TARGET_BITS'({var_clamp, 16'h0000});
        pick_thr    = PICK_BITS'(in_pick) * PICK_BITS'(cum_reg[NUM_STEPS-1]);
    end

    logic [PROD_BITS-1:0]   prod;
    logic [TARGET_BITS-1:0] target_new;

    assign prod       = PROD_BITS'(base_reg) * PROD_BITS'(factor_reg);
    assign target_new = recip_reg[DIV100_SHIFT +: TARGET_BITS];

    // tick evaluation
    logic                   btn_rise;
    logic [MODE_BITS-1:0]   mode_next;
    logic [NUM_STEPS-1:0]   act_btn;
    logic [NUM_STEPS-1:0]   active_next;
    logic [TARGET_BITS-1:0] target_use;
    logic                   overrun;
    logic                   fire;
    logic                   apply;
    logic [TIME_BITS-1:0]   elapsed_mid;
    logic [TIME_BITS-1:0]   elapsed_next;
    logic [STEP_IDX_W-1:0]  pick_sel;
    logic [NUM_STEPS-1:0]   indep_mask;
    logic [STEP_IDX_W-1:0]  adv_cur;
    logic [STEP_IDX_W-1:0]  adv_nxt;
    logic [STEP_IDX_W-1:0]  adv_idx;
    logic [NUM_STEPS-1:0]   adv_mask;
    logic [CV_BITS-1:0]     held_next [NUM_STEPS];
    logic [OUT_TDATA_W-1:0] out_word;

    always_comb begin
        btn_rise = btn_reg & ~button_prev_reg;
        mode_next = mode_reg;
        act_btn   = active_reg;
        if (btn_rise) begin
            mode_next = (mode_reg >= MODE_ADVANCE) ? MODE_PICK : mode_reg + 2'd1;
            act_btn   = (mode_next == MODE_ADVANCE) ? NUM_STEPS'(1) : '0;
        end

        target_use = draw_reg ? target_new : target_reg;
        overrun    = gate_reg && (CMP_W'(elapsed_reg) > CMP_W'(target_use));
        fire       = gate_reg && (draw_reg || overrun);
        apply      = fire && (cum_reg[NUM_STEPS-1] != '0);

        elapsed_mid  = overrun ? '0 : elapsed_reg;
        elapsed_next = '0;
        if (gate_reg) begin
            elapsed_next = (elapsed_mid != TIME_MAX) ? elapsed_mid + 1'b1 : elapsed_mid;
        end

        pick_sel = '0;
        for (int i = NUM_STEPS - 1; i >= 0; i--) begin
            if ({cum_reg[i], 16'h0000} > pick_thr_reg) begin
                pick_sel = STEP_IDX_W'(i);
            end
        end

        for (int i = 0; i < NUM_STEPS; i++) begin
            indep_mask[i] = wrbr_passes(weights_reg[WEIGHT_BITS*i +: WEIGHT_BITS],
                                        lanes_reg[WEIGHT_BITS*i +: WEIGHT_BITS]);
        end

        adv_cur = '0;
        for (int i = NUM_STEPS - 1; i >= 0; i--) begin
            if (act_btn[i]) begin
                adv_cur = STEP_IDX_W'(i);
            end
        end
        adv_nxt = adv_cur;
        adv_idx = adv_cur;
        for (int k = NUM_STEPS; k >= 1; k--) begin
            adv_idx = STEP_IDX_W'((int'(adv_cur) + k) % NUM_STEPS);
            if (weights_reg[WEIGHT_BITS*adv_idx +: WEIGHT_BITS] != '0) begin
                adv_nxt = adv_idx;
            end
        end
        adv_mask = act_btn;
        if (wrbr_passes(weights_reg[WEIGHT_BITS*adv_nxt +: WEIGHT_BITS],
                        lanes_reg[WEIGHT_BITS-1:0])) begin
            adv_mask[adv_cur] = 1'b0;
            adv_mask[adv_nxt] = 1'b1;
        end

        active_next = act_btn;
        if (apply) begin
            case (mode_next)
                MODE_PICK: begin
                    active_next = '0;
                    active_next[pick_sel] = 1'b1;
                end
                MODE_INDEP:   active_next = indep_mask;
                MODE_ADVANCE: active_next = adv_mask;
                default:      active_next = act_btn;
            endcase
        end

        out_word = '0;
        out_word[NUM_STEPS-1:0]          = active_next;
        out_word[NUM_STEPS +: MODE_BITS] = mode_next;
        for (int i = 0; i < NUM_STEPS; i++) begin
            held_next[i] = (apply && active_next[i] && hold_reg[i]) ? cv_reg : held_reg[i];
            if (hold_reg[i]) begin
                out_word[OUT_CV_LSB + CV_BITS*i +: CV_BITS] = held_next[i];
            end else if (active_next[i]) begin
                out_word[OUT_CV_LSB + CV_BITS*i +: CV_BITS] = cv_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= BASE_RESET;
            var_reg     <= VAR_RESET;
            weights_reg <= WEIGHTS_RESET;
            hold_reg    <= HOLD_RESET;
            cum_reg     <= wrbr_prefix(WEIGHTS_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BASE_PERIOD: base_reg <= cfg_data[BASE_BITS-1:0];
                REG_VARIATION:   var_reg  <= cfg_data[VAR_BITS-1:0];
                REG_WEIGHTS: begin
                    weights_reg <= cfg_data[LANE_BITS-1:0];
                    cum_reg     <= wrbr_prefix(cfg_data[LANE_BITS-1:0]);
                end
                REG_HOLD_MASK:   hold_reg <= cfg_data[NUM_STEPS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            gate_reg     <= in_gate;
            btn_reg      <= in_btn;
            cv_reg       <= in_cv;
            lanes_reg    <= in_lanes;
            factor_reg   <= factor_wide[FACTOR_BITS-1:0];
            pick_thr_reg <= pick_thr;
            draw_reg     <= status.draw;
        end
        if (cmd.prod_en) begin
            scaled_reg <= prod[PROD_BITS-1 -: QUOT_BITS];
        end
        if (cmd.quot_en) begin
            recip_reg <= (2*QUOT_BITS)'(scaled_reg) * (2*QUOT_BITS)'(DIV100_MAGIC);
        end
        if (cmd.eval_en) begin
            out_data_reg <= out_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_PICK;
            active_reg      <= '0;
            elapsed_reg     <= '0;
            target_reg      <= '0;
            armed_reg       <= 1'b0;
            button_prev_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_STEPS; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            if (cmd.eval_en) begin
                mode_reg        <= mode_next;
                active_reg      <= active_next;
                elapsed_reg     <= elapsed_next;
                target_reg      <= target_use;
                armed_reg       <= gate_reg;
                button_prev_reg <= btn_reg;
                for (int i = 0; i < NUM_STEPS; i++) begin
                    held_reg[i] <= held_next[i];
                end
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/weighted_random_burst_router.sv
// Weighted random burst router, top level; uses wrbr_pkg, wrbr_ctrl and
// wrbr_datapath. One input word is one sample tick and yields one result word.
// A tick with the gate low or already armed goes from capture straight to
// evaluation; the tick that opens the gate first has its jittered period
// target pass through a 24x24 multiply and a 32x32 reciprocal multiply
// (divide by 100) in turn. A finished word waits in the output register while
// the next input word is taken; evaluation stalls only if that register is
// still full. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module weighted_random_burst_router
    import wrbr_pkg::*;
#(
    parameter int TIME_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // gate[0], mode_button[1], cv_sample[17:2], random_jitter[33:18],
    // random_pick[49:34], random_lanes[113:50], zero pad[119:114]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // gate_mask[7:0], mode_now[9:8], step_cv_0[25:10] .. step_cv_7[137:122],
    // zero pad[143:138]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    wrbr_cmd_t    cmd;
    wrbr_status_t status;

    assign cfg_ready = 1'b1;

    wrbr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    wrbr_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_axis_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata)
    );

endmodule

// File: rtl/core/wrbr_checker.sv
// Port-level checks of the router, bound to the top level.
// Depends on wrbr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wrbr_checker
    import wrbr_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    `WRBR_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_axis_tvalid, "output word valid after reset")

    `WRBR_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

    `WRBR_ASSERT(a_one_word_in_flight, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken twice in a row")

    `WRBR_ASSERT(a_mode_legal, aclk, aresetn, m_axis_tvalid |-> m_axis_tdata[NUM_STEPS +: MODE_BITS] != 2'b11, "illegal mode in output word")

    `WRBR_ASSERT(a_single_gate, aclk, aresetn, m_axis_tvalid && m_axis_tdata[NUM_STEPS +: MODE_BITS] != MODE_INDEP |-> $onehot0(m_axis_tdata[NUM_STEPS-1:0]), "several gates outside independent mode")

endmodule

bind weighted_random_burst_router wrbr_checker u_wrbr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
